@@ rtl/tct_pkg.sv @@
package tct_pkg;

  // Operation carried by an input word.
  typedef enum logic [1:0] {
    KIND_INSERT     = 2'd0,
    KIND_SEEK       = 2'd1,
    KIND_READ_NEXT  = 2'd2,
    KIND_READ_INDEX = 2'd3
  } kind_e;

  // Status reported with every result word.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_ENTRY = 2'd1,
    STATUS_FULL     = 2'd2
  } status_e;

  // Configuration register indexes.
  localparam logic CFG_TIME_OFFSET  = 1'b0;
  localparam logic CFG_BUFFER_LIMIT = 1'b1;

  localparam logic [12:0] BUFFER_LIMIT_RESET = 13'd256;

  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_INS_SHIFT = 3'd1,
    ST_SEEK_SCAN = 3'd2,
    ST_READ_WAIT = 3'd3,
    ST_FINISH    = 3'd4
  } state_e;

  typedef struct packed {
    kind_e        kind;
    logic [31:0]  time_value;
    logic [15:0]  text_handle;
    logic [11:0]  text_length;
    logic [7:0]   entry_index;
  } in_word_t;

  typedef struct packed {
    status_e      status;
    logic [31:0]  entry_time;
    logic [15:0]  entry_handle;
    logic [11:0]  clipped_length;
    logic [8:0]   cursor;
    logic [8:0]   entry_count;
    logic [11:0]  longest_length;
  } out_word_t;

  // One stored cue.
  typedef struct packed {
    logic [31:0]  cue_time;
    logic [15:0]  cue_handle;
    logic [11:0]  cue_length;
  } cue_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;        // take the input word and issue the first table read
    logic     step_ins;    // move one entry up and read the one below it
    logic     place_ins;   // write the new cue at the pointer
    logic     step_seek;   // pass one entry and read the next
    logic     end_seek;    // set the cursor from the scan pointer
    logic     adv_cursor;  // advance the cursor after a read-next
    logic     out_load;    // fill the result register
    status_e  out_status;
    logic     out_entry;   // result carries the entry read
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e  live_kind;
    kind_e  cur_kind;
    logic   full;
    logic   found;
    logic   shift_more;
    logic   seek_more;
  } dp_sts_t;

endpackage

@@ rtl/timed_cue_table.sv @@
// Timed cue table: a table of cues held in order of start time.
// An input word names one of four operations (insert, seek, read next, read by
// index) and each accepted word gives exactly one result word, in order.
// Both channels use valid and stall; a word moves at a rising edge at which
// valid is high and stall is low. Configuration registers (time offset, buffer
// limit) are written through cfg_we_i, cfg_index_i and cfg_wdata_i; the user
// must write them only while the block is idle; the block does not enforce it.
// Words are handled one at a time. A read that finds its entry passes the read
// wait state before the result register is loaded; a read past the end or a
// refused insert goes from idle straight to loading the result. A seek passes
// one entry per step and an insert moves one entry up per step, over at most
// TABLE_DEPTH entries; the next word is accepted once the result register is
// loaded and the block is back in idle. The pace of the walk is set by the
// single table memory, read and written once per cycle as entries are walked.
// A finished result sits in the output register; the next word is accepted
// while it waits, and only the hand-over of the following result waits for the
// receiver to stop stalling.
// Reset clears the entry count, cursor and longest length and restores the
// configuration registers; the table contents are not cleared, as only entries
// below the count are ever used.
module timed_cue_table #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tct_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tct_pkg::out_word_t out_word_o
);
  import tct_pkg::*;

  // The controller sequences each operation; the datapath owns the table,
  // the counters and the result register.
  dp_cmd_t cmd;
  dp_sts_t sts;

  tct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tct_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_word_o  (out_word_o)
  );

endmodule

@@ rtl/tct_ctrl.sv @@
module tct_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  tct_pkg::dp_sts_t  sts_i,
  output tct_pkg::dp_cmd_t  cmd_o
);
  import tct_pkg::*;

  state_e  state_q, state_d;
  status_e res_status_q, res_status_d;
  logic    res_entry_q, res_entry_d;
  logic    out_valid_q, out_valid_d;
  logic    can_load;

  assign can_load = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d      = state_q;
    res_status_d = res_status_q;
    res_entry_d  = res_entry_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_status_d = STATUS_OK;
          res_entry_d  = 1'b0;
          case (sts_i.live_kind)
            KIND_INSERT: begin
              if (sts_i.full) begin
                res_status_d = STATUS_FULL;
                state_d      = ST_FINISH;
              end else begin
                state_d = ST_INS_SHIFT;
              end
            end
            KIND_SEEK: begin
              state_d = ST_SEEK_SCAN;
            end
            default: begin
              if (sts_i.found) begin
                res_entry_d = 1'b1;
                state_d     = ST_READ_WAIT;
              end else begin
                res_status_d = STATUS_NO_ENTRY;
                state_d      = ST_FINISH;
              end
            end
          endcase
        end
      end
      ST_INS_SHIFT: begin
        if (!sts_i.shift_more) begin
          state_d = ST_FINISH;
        end
      end
      ST_SEEK_SCAN: begin
        if (!sts_i.seek_more) begin
          state_d = ST_FINISH;
        end
      end
      ST_READ_WAIT: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (can_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.out_status = res_status_q;
    cmd_o.out_entry  = res_entry_q;
    in_stall_o       = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_INS_SHIFT: begin
        cmd_o.step_ins  = sts_i.shift_more;
        cmd_o.place_ins = !sts_i.shift_more;
      end
      ST_SEEK_SCAN: begin
        cmd_o.step_seek = sts_i.seek_more;
        cmd_o.end_seek  = !sts_i.seek_more;
      end
      ST_READ_WAIT: begin
        cmd_o.adv_cursor = (sts_i.cur_kind == KIND_READ_NEXT);
      end
      ST_FINISH: begin
        cmd_o.out_load = can_load;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      res_status_q <= STATUS_OK;
      res_entry_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      res_status_q <= res_status_d;
      res_entry_q  <= res_entry_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/tct_datapath.sv @@
module tct_datapath #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  input  tct_pkg::in_word_t  in_word_i,
  input  tct_pkg::dp_cmd_t   cmd_i,
  output tct_pkg::dp_sts_t   sts_o,
  output tct_pkg::out_word_t out_word_o
);
  import tct_pkg::*;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SEL_W = (CNT_W > 8) ? CNT_W : 8;

  logic [31:0]      offset_q;
  logic [12:0]      blim_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] cursor_q, cursor_d;
  logic [11:0]      maxlen_q, maxlen_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [31:0]      tt_q, tt_d;
  in_word_t         item_q;
  cue_t             rd_q;
  out_word_t        out_q;
  cue_t             mem_q [TABLE_DEPTH];

  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  cue_t             wr_data;

  logic [SEL_W-1:0] sel_live;
  logic             found_live;
  logic [31:0]      mag;
  logic [31:0]      tt_seek;
  logic [CNT_W-1:0] count_m1, ptr_m1, ptr_m2, ptr_p1;
  logic [12:0]      lim, lim_m1;
  logic [11:0]      clip_len;
  logic [31:0]      cursor_ext, count_ext;

  // Selected entry of a read and whether the table holds it.
  assign sel_live   = (in_word_i.kind == KIND_READ_NEXT) ? SEL_W'(cursor_q)
                                                         : SEL_W'(in_word_i.entry_index);
  assign found_live = sel_live < SEL_W'(count_q);

  // A negative offset only applies when the time exceeds its magnitude.
  assign mag     = 32'd0 - offset_q;
  assign tt_seek = (!offset_q[31] || (in_word_i.time_value > mag))
                   ? in_word_i.time_value + offset_q : in_word_i.time_value;

  assign count_m1 = count_q - 1'b1;
  assign ptr_m1   = ptr_q - 1'b1;
  assign ptr_m2   = ptr_q - 2'd2;
  assign ptr_p1   = ptr_q + 1'b1;

  assign sts_o.live_kind  = in_word_i.kind;
  assign sts_o.cur_kind   = item_q.kind;
  assign sts_o.full       = (count_q == CNT_W'(TABLE_DEPTH));
  assign sts_o.found      = found_live;
  assign sts_o.shift_more = (ptr_q != '0) && (rd_q.cue_time > tt_q);
  assign sts_o.seek_more  = (ptr_q < count_q) && (rd_q.cue_time <= tt_q);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = ptr_q[IDX_W-1:0];
    wr_data = rd_q;
    ptr_d   = ptr_q;
    tt_d    = tt_q;
    if (cmd_i.load) begin
      rd_en = 1'b1;
      case (in_word_i.kind)
        KIND_INSERT: begin
          ptr_d   = count_q;
          tt_d    = in_word_i.time_value;
          rd_addr = count_m1[IDX_W-1:0];
        end
        KIND_SEEK: begin
          ptr_d   = '0;
          tt_d    = tt_seek;
          rd_addr = '0;
        end
        default: begin
          rd_addr = sel_live[IDX_W-1:0];
        end
      endcase
    end
    if (cmd_i.step_ins) begin
      wr_en   = 1'b1;
      rd_en   = 1'b1;
      rd_addr = ptr_m2[IDX_W-1:0];
      ptr_d   = ptr_m1;
    end
    if (cmd_i.place_ins) begin
      wr_en   = 1'b1;
      wr_data = '{cue_time: tt_q, cue_handle: item_q.text_handle,
                  cue_length: item_q.text_length};
    end
    if (cmd_i.step_seek) begin
      rd_en   = 1'b1;
      rd_addr = ptr_p1[IDX_W-1:0];
      ptr_d   = ptr_p1;
    end
  end

  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    maxlen_d = maxlen_q;
    if (cmd_i.place_ins) begin
      count_d = count_q + 1'b1;
      if (item_q.text_length > maxlen_q) begin
        maxlen_d = item_q.text_length;
      end
    end
    if (cmd_i.end_seek) begin
      cursor_d = (ptr_q != '0) ? ptr_m1 : '0;
    end
    if (cmd_i.adv_cursor) begin
      cursor_d = cursor_q + 1'b1;
    end
  end

  // Length clipped to the buffer limit less one; a zero limit acts as one.
  assign lim      = (blim_q == '0) ? 13'd1 : blim_q;
  assign lim_m1   = lim - 1'b1;
  assign clip_len = ({1'b0, rd_q.cue_length} >= lim_m1) ? lim_m1[11:0] : rd_q.cue_length;

  assign cursor_ext = 32'(cursor_q);
  assign count_ext  = 32'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      blim_q   <= BUFFER_LIMIT_RESET;
      count_q  <= '0;
      cursor_q <= '0;
      maxlen_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_TIME_OFFSET) begin
          offset_q <= cfg_wdata_i;
        end else begin
          blim_q <= cfg_wdata_i[12:0];
        end
      end
      count_q  <= count_d;
      cursor_q <= cursor_d;
      maxlen_q <= maxlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    tt_q  <= tt_d;
    if (cmd_i.load) begin
      item_q <= in_word_i;
    end
    if (cmd_i.out_load) begin
      out_q.status         <= cmd_i.out_status;
      out_q.entry_time     <= cmd_i.out_entry ? rd_q.cue_time : '0;
      out_q.entry_handle   <= cmd_i.out_entry ? rd_q.cue_handle : '0;
      out_q.clipped_length <= cmd_i.out_entry ? clip_len : '0;
      out_q.cursor         <= cursor_ext[8:0];
      out_q.entry_count    <= count_ext[8:0];
      out_q.longest_length <= maxlen_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign out_word_o = out_q;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import tct_pkg::*;

  localparam int DEPTH = 256;
  // An insert or a seek walks at most DEPTH entries plus the overhead of its
  // other states. Add the longest receiver stall and the longest sender gap to
  // that, and the limit below leaves a wide margin over the slowest word.
  localparam int IDLE_LIMIT = 4000;
  // Cycles allowed after the last expected word, long enough for a full walk.
  localparam int SETTLE_CYCLES = 300;

  logic       clk = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_index_i = CFG_TIME_OFFSET;
  logic [31:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  in_word_t   in_word_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_word_t  out_word_o;

  timed_cue_table #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Our own copy of the cue table, kept in step with every accepted word.
  logic [31:0] shadow_time   [DEPTH];
  logic [15:0] shadow_handle [DEPTH];
  logic [11:0] shadow_length [DEPTH];
  int          shadow_count = 0;
  int          shadow_cursor = 0;
  logic [11:0] shadow_longest = '0;
  logic [31:0] offset_reg = '0;
  logic [12:0] limit_reg = BUFFER_LIMIT_RESET;

  out_word_t expected_words[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        quiet_cycles = 0;
  int        stall_run = 0;
  bit        gaps_on = 1'b1;
  bit        stalls_on = 1'b1;

  // A stored length as the reader sees it: limited to one less than the buffer
  // size, where a buffer size of zero counts as one.
  function automatic logic [11:0] clip_to_buffer(logic [11:0] len);
    logic [12:0] lim;
    lim = (limit_reg == 13'd0) ? 13'd1 : limit_reg;
    if ({1'b0, len} >= lim - 13'd1) return 12'(lim - 13'd1);
    return len;
  endfunction

  // Seek target after correction. A positive offset always applies and wraps
  // at 32 bits; a negative one applies only when the target is strictly
  // greater than its magnitude.
  function automatic logic [31:0] corrected_target(logic [31:0] t);
    logic [31:0] mag;
    mag = 32'd0 - offset_reg;
    if (!offset_reg[31]) return t + offset_reg;
    if (t > mag) return t - mag;
    return t;
  endfunction

  // Applies one word to the shadow table and returns the result word that the
  // block must give for it.
  function automatic out_word_t apply_cue_op(in_word_t w);
    out_word_t   r;
    int          pos;
    int          sel;
    logic [31:0] t;
    r = '0;
    r.status = STATUS_OK;
    case (w.kind)
      KIND_INSERT: begin
        if (shadow_count >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_time[pos] <= w.time_value) pos++;
          for (int j = shadow_count; j > pos; j--) begin
            shadow_time[j]   = shadow_time[j-1];
            shadow_handle[j] = shadow_handle[j-1];
            shadow_length[j] = shadow_length[j-1];
          end
          shadow_time[pos]   = w.time_value;
          shadow_handle[pos] = w.text_handle;
          shadow_length[pos] = w.text_length;
          shadow_count++;
          if (w.text_length > shadow_longest) shadow_longest = w.text_length;
        end
      end
      KIND_SEEK: begin
        t = corrected_target(w.time_value);
        pos = 0;
        while (pos < shadow_count && shadow_time[pos] <= t) pos++;
        shadow_cursor = (pos > 0) ? pos - 1 : 0;
      end
      default: begin
        sel = (w.kind == KIND_READ_NEXT) ? shadow_cursor : int'(w.entry_index);
        if (sel < shadow_count) begin
          r.entry_time     = shadow_time[sel];
          r.entry_handle   = shadow_handle[sel];
          r.clipped_length = clip_to_buffer(shadow_length[sel]);
          if (w.kind == KIND_READ_NEXT) shadow_cursor++;
        end else begin
          r.status = STATUS_NO_ENTRY;
        end
      end
    endcase
    r.cursor         = 9'(shadow_cursor);
    r.entry_count    = 9'(shadow_count);
    r.longest_length = shadow_longest;
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [95:0] want, logic [95:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: result %0d, %s: expected %0h, got %0h",
               $time, results_seen, what, want, got);
  endtask

  task automatic compare_result(out_word_t want, out_word_t got);
    if (got.status !== want.status) flag_mismatch("status", want.status, got.status);
    if (got.entry_time !== want.entry_time)
      flag_mismatch("entry_time", want.entry_time, got.entry_time);
    if (got.entry_handle !== want.entry_handle)
      flag_mismatch("entry_handle", want.entry_handle, got.entry_handle);
    if (got.clipped_length !== want.clipped_length)
      flag_mismatch("clipped_length", want.clipped_length, got.clipped_length);
    if (got.cursor !== want.cursor) flag_mismatch("cursor", want.cursor, got.cursor);
    if (got.entry_count !== want.entry_count)
      flag_mismatch("entry_count", want.entry_count, got.entry_count);
    if (got.longest_length !== want.longest_length)
      flag_mismatch("longest_length", want.longest_length, got.longest_length);
  endtask

  // Every result word taken at a rising edge is held against the oldest
  // expectation. Outputs are read before the edge's own updates land.
  always @(posedge clk) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (expected_words.size() == 0)
        flag_mismatch("result word with nothing expected", '0, out_word_o);
      else
        compare_result(expected_words.pop_front(), out_word_o);
      results_seen++;
    end
  end

  // The receiver stalls in runs: mostly short, now and then long, and not at
  // all while stalls are switched off.
  always @(negedge clk) begin
    if (!stalls_on) begin
      out_stall_i <= 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else if ($urandom_range(0, 99) < 40) begin
      out_stall_i <= 1'b1;
      stall_run = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 2)
                                                 : $urandom_range(9, 39);
    end else begin
      out_stall_i <= 1'b0;
      stall_run = $urandom_range(0, 7);
    end
  end

  // Ends a run that has stopped moving words in either direction.
  always @(posedge clk) begin
    if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_word_t make_word(kind_e k, logic [31:0] t, logic [15:0] h,
                                         logic [11:0] len, logic [7:0] idx);
    in_word_t w;
    w.kind        = k;
    w.time_value  = t;
    w.text_handle = h;
    w.text_length = len;
    w.entry_index = idx;
    return w;
  endfunction

  // Offers one word, holds it steady while the block stalls, and records the
  // expected result at the edge that takes it. Valid is only lowered when a
  // gap is due, so it is never dropped and raised within one step.
  task automatic send_word(in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    expected_words.push_back(apply_cue_op(w));
  endtask

  // Stops offering words and waits for every expected result to come back.
  task automatic wait_until_idle();
    @(negedge clk);
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [31:0] value);
    @(negedge clk);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk);
    cfg_we_i <= 1'b0;
    if (idx == CFG_TIME_OFFSET) offset_reg = value;
    else limit_reg = value[12:0];
  endtask

  // Registers only change while the block is idle.
  task automatic set_config(logic [31:0] offset, logic [12:0] limit);
    wait_until_idle();
    write_register(CFG_TIME_OFFSET, offset);
    write_register(CFG_BUFFER_LIMIT, {19'd0, limit});
  endtask

  // Reads on a table that holds nothing, and a seek that has nowhere to go.
  task automatic test_empty_table();
    send_word(make_word(KIND_READ_NEXT, 32'd0, 16'd0, 12'd0, 8'd0));
    send_word(make_word(KIND_READ_INDEX, 32'd0, 16'd0, 12'd0, 8'd255));
    send_word(make_word(KIND_SEEK, 32'hFFFF_FFFF, 16'd0, 12'd0, 8'd0));
  endtask

  // Inserts out of order, with equal times landing after the earlier ones and
  // the extremes of every field.
  task automatic test_insert_order();
    send_word(make_word(KIND_INSERT, 32'd100, 16'hFFFF, 12'd4095, 8'd0));
    send_word(make_word(KIND_INSERT, 32'd50, 16'h0000, 12'd0, 8'hFF));
    send_word(make_word(KIND_INSERT, 32'd100, 16'h0001, 12'd10, 8'd0));
    send_word(make_word(KIND_INSERT, 32'd0, 16'h1234, 12'd300, 8'd0));
    send_word(make_word(KIND_INSERT, 32'hFFFF_FFFF, 16'h8000, 12'd2048, 8'd0));
    send_word(make_word(KIND_INSERT, 32'd100, 16'h0002, 12'd5, 8'd0));
  endtask

  // The table now holds times 0, 50, 100, 100, 100 and the largest value.
  // Seeks land on the last equal entry; reads run off the end and stop there.
  task automatic test_seek_and_read();
    send_word(make_word(KIND_SEEK, 32'd100, 16'd0, 12'd0, 8'd0));
    send_word(make_word(KIND_READ_NEXT, 32'd0, 16'd0, 12'd0, 8'd0));
    send_word(make_word(KIND_READ_NEXT, 32'd0, 16'd0, 12'd0, 8'd0));
    send_word(make_word(KIND_READ_NEXT, 32'd0, 16'd0, 12'd0, 8'd0));
    send_word(make_word(KIND_SEEK, 32'd49, 16'd0, 12'd0, 8'd0));
    send_word(make_word(KIND_READ_INDEX, 32'd0, 16'd0, 12'd0, 8'd5));
    send_word(make_word(KIND_READ_INDEX, 32'd0, 16'd0, 12'd0, 8'd6));
  endtask

  // Positive offsets, wrapping ones, and negative ones both above and at
  // their magnitude.
  task automatic test_time_offset();
    set_config(32'd50, BUFFER_LIMIT_RESET);
    send_word(make_word(KIND_SEEK, 32'd50, 16'd0, 12'd0, 8'd0));
    set_config(32'hFFFF_FFCE, BUFFER_LIMIT_RESET);
    send_word(make_word(KIND_SEEK, 32'd150, 16'd0, 12'd0, 8'd0));
    send_word(make_word(KIND_SEEK, 32'd50, 16'd0, 12'd0, 8'd0));
    set_config(32'h8000_0000, BUFFER_LIMIT_RESET);
    send_word(make_word(KIND_SEEK, 32'h8000_0000, 16'd0, 12'd0, 8'd0));
    set_config(32'h7FFF_FFFF, BUFFER_LIMIT_RESET);
    send_word(make_word(KIND_SEEK, 32'h8000_0001, 16'd0, 12'd0, 8'd0));
    set_config(32'hFFFF_FFFF, BUFFER_LIMIT_RESET);
    send_word(make_word(KIND_SEEK, 32'd2, 16'd0, 12'd0, 8'd0));
  endtask

  // Entry 2 holds the longest text. A zero buffer size reports nothing, and
  // sizes beyond the largest length leave it whole.
  task automatic test_length_clipping();
    set_config(32'd0, 13'd0);
    send_word(make_word(KIND_READ_INDEX, 32'd0, 16'd0, 12'd0, 8'd2));
    set_config(32'd0, 13'd2);
    send_word(make_word(KIND_READ_INDEX, 32'd0, 16'd0, 12'd0, 8'd2));
    set_config(32'd0, 13'd4096);
    send_word(make_word(KIND_READ_INDEX, 32'd0, 16'd0, 12'd0, 8'd2));
    set_config(32'd0, 13'd8191);
    send_word(make_word(KIND_READ_INDEX, 32'd0, 16'd0, 12'd0, 8'd2));
  endtask

  // A random word. Insert times are often drawn from a small set so that
  // equal times are common, and seek targets are often chosen so that, once
  // corrected, they fall on or just beside a stored time.
  function automatic in_word_t random_word();
    in_word_t    w;
    int          r;
    logic [31:0] base;
    r = $urandom_range(0, 99);
    w = make_word(KIND_READ_INDEX, $urandom, 16'($urandom), 12'($urandom), 8'($urandom));
    if (r < 35) begin
      w.kind = KIND_INSERT;
      r = $urandom_range(0, 99);
      if (r < 25) w.time_value = 32'(1000 * $urandom_range(0, 15));
      else if (r < 30) w.time_value = (r < 28) ? 32'd0 : 32'hFFFF_FFFF;
      r = $urandom_range(0, 99);
      if (r < 10) w.text_length = 12'd4095;
      else if (r < 20) w.text_length = 12'd0;
    end else if (r < 55) begin
      w.kind = KIND_SEEK;
      if (shadow_count > 0 && $urandom_range(0, 99) < 60) begin
        base = shadow_time[$urandom_range(0, shadow_count - 1)];
        base = base + 32'($urandom_range(0, 2)) - 32'd1;
        w.time_value = base - offset_reg;
      end
    end else if (r < 80) begin
      w.kind = KIND_READ_NEXT;
    end else if (shadow_count > 0 && $urandom_range(0, 99) < 75) begin
      w.entry_index = 8'($urandom_range(0, shadow_count - 1));
    end
    return w;
  endfunction

  task automatic run_random_phase(logic [31:0] offset, logic [12:0] limit,
                                  bit gaps, bit stalls, int count);
    set_config(offset, limit);
    gaps_on = gaps;
    stalls_on = stalls;
    repeat (count) send_word(random_word());
  endtask

  // Random traffic over several settings. Inserts come often enough that the
  // table fills part of the way through, so later phases also meet refused
  // inserts and scans over the whole table. One phase runs without any gaps or stalls.
  task automatic test_random_traffic();
    run_random_phase(32'd0, 13'd256, 1'b1, 1'b1, 300);
    run_random_phase(32'h0000_1000, 13'd100, 1'b1, 1'b1, 250);
    run_random_phase(32'hFFFF_F000, 13'd4096, 1'b0, 1'b0, 200);
    run_random_phase(32'h8000_0000, 13'd0, 1'b1, 1'b1, 250);
    run_random_phase(32'h7FFF_FFFF, 13'd8191, 1'b1, 1'b1, 250);
    run_random_phase($urandom, 13'($urandom), 1'b1, 1'b1, 250);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_ni <= 1'b1;
    test_empty_table();
    test_insert_order();
    test_seek_and_read();
    test_time_offset();
    test_length_clipping();
    test_random_traffic();
    wait_until_idle();
    // Any word that turns up during this wait has no expectation and fails.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tct_pkg.sv
rtl/tct_ctrl.sv
rtl/tct_datapath.sv
rtl/timed_cue_table.sv
tb/testbench.sv
